@@ hdl/pcdac_pkg.sv @@
// Shared types and constants for the pulsed current converter code generator.
// No dependencies; imported by every module of the block.
package pcdac_pkg;

  // converter code and cache widths
  localparam int CODE_W        = 12;
  localparam int CACHE_W       = 16;
  localparam logic [CACHE_W-1:0] CACHE_EMPTY = 16'hFFFF;

  // time base: ticks per second and the widest pulse period
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int PERIOD_W         = $clog2(TICKS_PER_SECOND + 1);

  // serial divider: 32-bit dividend, one quotient bit per cycle
  localparam int DVD_W  = 32;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // configuration register fields
  localparam int FREQ_W = 8;
  localparam int DUTY_W = 7;
  localparam logic [FREQ_W-1:0] FREQ_MIN = 8'd1;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 8'd100;
  localparam int PCT_SCALE = 100;

  // product width for the duty compare: period * duty and 100 * (phase + 1)
  localparam int PROD_W = PERIOD_W + DUTY_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CODE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE = 3'd0,
    REG_PULSE     = 3'd1,
    REG_FREQ      = 3'd2,
    REG_DUTY      = 3'd3,
    REG_ENABLE    = 3'd4,
    REG_CONV_RDY  = 3'd5
  } cfg_reg_t;

  // divider control and status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/pcdac_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle over the 32-bit dividend.
// Depends on pcdac_pkg; shared by the period computation and the phase modulo.
module pcdac_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [pcdac_pkg::DVD_W-1:0]        dividend,
  input  logic [pcdac_pkg::PERIOD_W-1:0]     divisor,
  output pcdac_pkg::div_stat_t               stat,
  output logic [pcdac_pkg::PERIOD_W-1:0]     quotient,
  output logic [pcdac_pkg::PERIOD_W-1:0]     remainder
);
  import pcdac_pkg::*;

  logic [DVD_W-1:0]    dvd_r;      // dividend shifts out the top, quotient in the bottom
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] dsr_r;
  logic [STEP_W-1:0]   cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                qbit;

  // one restoring step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = (trial >= {1'b0, dsr_r});

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r[PERIOD_W-1:0];
  assign remainder = rem_r;

endmodule

@@ hdl/pulsed_current_dac_code_generator_unit.sv @@
// Top level of the pulsed current converter code generator.
// Depends on pcdac_pkg and pcdac_div.
//
// Usage:
//   in_*  : one transaction per time sample; in_tdata is the 32-bit tick count.
//   out_* : one transaction per input; out_tdata[11:0] is the converter code,
//           out_tuser is the write strobe (code differs from the last code written
//           and the converter is present).
//   cfg_* : register writes, always accepted; index 0..5 selects amplitude, mode,
//           frequency, duty, enable, converter present. Other indexes are ignored.
// Flow:
//   Pulsed mode: the item runs through the 32-step serial divider that forms
//   time mod period, then through the multiply, compare and output steps.
//   Constant or disabled output: the item goes straight to the output step.
//   One item is in flight at a time; in_tready is high only in the idle state.
//   A frequency write makes the same divider form 1000000/freq: in_tready stays
//   low until the new period is stored.
// Reset: registers take their reset values, period is 1000000, cache is 0xFFFF.
// Stall: the result sits in an output register; the next item is accepted and
//   worked on, and it waits for the output register only at its last step.
module pulsed_current_dac_code_generator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream: [31:0] time_us
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pcdac_pkg::DVD_W-1:0]          in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,  // [11:0] dac_code, [15:12] zero
  output logic                                 out_tuser,  // [0] write_strobe
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcdac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcdac_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pcdac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_MOD,
    ST_MUL,
    ST_CMP,
    ST_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [CODE_W-1:0]   amp_r;
  logic                pulse_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [DUTY_W-1:0]   duty_r;
  logic                enable_r;
  logic                conv_rdy_r;
  logic                pend_r;      // period must be recomputed
  logic [PERIOD_W-1:0] period_r;

  // item datapath
  logic [PERIOD_W-1:0] phase_r;
  logic [PROD_W-1:0]   lhs_r;
  logic [PROD_W-1:0]   rhs_r;
  logic [CODE_W-1:0]   code_r;
  logic [CACHE_W-1:0]  cache_r;

  // output register
  logic                out_valid_r;
  logic [CODE_W-1:0]   out_code_r;
  logic                out_strobe_r;

  // divider hookup
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  div_stat_t           div_stat;
  logic [PERIOD_W-1:0] div_quot;
  logic [PERIOD_W-1:0] div_rem;

  logic                in_acc;
  logic                cfg_acc;
  logic                run_period;
  logic                run_mod;
  logic                out_free;
  logic                strobe;
  logic [FREQ_W-1:0]   freq_clamp;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_tready = (state_r == ST_IDLE) && !pend_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // frequency clamped to the supported range
  always_comb begin
    if (freq_r < FREQ_MIN) begin
      freq_clamp = FREQ_MIN;
    end else if (freq_r > FREQ_MAX) begin
      freq_clamp = FREQ_MAX;
    end else begin
      freq_clamp = freq_r;
    end
  end

  // divider requests: period after a frequency write, phase for a pulsed item
  assign run_period   = (state_r == ST_IDLE) && pend_r;
  assign run_mod      = in_acc && enable_r && pulse_r;
  assign div_start    = run_period || run_mod;
  assign div_dividend = run_period ? DVD_W'(TICKS_PER_SECOND) : in_tdata;
  assign div_divisor  = run_period ? PERIOD_W'(freq_clamp) : period_r;

  pcdac_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // write strobe: converter present and code differs from the last code written
  assign strobe = conv_rdy_r && ({{(CACHE_W-CODE_W){1'b0}}, code_r} != cache_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r      <= '0;
      pulse_r    <= 1'b0;
      freq_r     <= FREQ_MIN;
      duty_r     <= '0;
      enable_r   <= 1'b0;
      conv_rdy_r <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMPLITUDE: amp_r      <= cfg_data[CODE_W-1:0];
        REG_PULSE:     pulse_r    <= cfg_data[0];
        REG_FREQ:      freq_r     <= cfg_data[FREQ_W-1:0];
        REG_DUTY:      duty_r     <= cfg_data[DUTY_W-1:0];
        REG_ENABLE:    enable_r   <= cfg_data[0];
        REG_CONV_RDY:  conv_rdy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state machine and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      period_r    <= PERIOD_W'(TICKS_PER_SECOND);
      cache_r     <= CACHE_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load from the last step, else drain on ready
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // a frequency write arriving with the period start keeps the request
      if (cfg_acc && (cfg_reg_t'(cfg_index) == REG_FREQ)) begin
        pend_r <= 1'b1;
      end else if (run_period) begin
        pend_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (run_period) begin
            state_r <= ST_PERIOD;
          end else if (run_mod) begin
            state_r <= ST_MOD;
          end else if (in_acc) begin
            code_r  <= enable_r ? amp_r : '0;
            state_r <= ST_OUT;
          end
        end
        ST_PERIOD: begin
          if (div_stat.done) begin
            period_r <= div_quot;
            state_r  <= ST_IDLE;
          end
        end
        ST_MOD: begin
          if (div_stat.done) begin
            phase_r <= div_rem;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          // phase < floor(period*duty/100)  <=>  100*phase + 100 <= period*duty
          lhs_r   <= PROD_W'(phase_r) * PROD_W'(PCT_SCALE) + PROD_W'(PCT_SCALE);
          rhs_r   <= PROD_W'(period_r) * PROD_W'(duty_r);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          code_r  <= (lhs_r <= rhs_r) ? amp_r : '0;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_code_r   <= code_r;
            out_strobe_r <= strobe;
            if (strobe) begin
              cache_r <= {{(CACHE_W-CODE_W){1'b0}}, code_r};
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-CODE_W){1'b0}}, out_code_r};
  assign out_tuser  = out_strobe_r;

endmodule

@@ hdl/pcdac_checker.sv @@
// Port-level checker for the pulsed current converter code generator, with bind.
// Depends on pcdac_pkg and the top level pulsed_current_dac_code_generator_unit.
module pcdac_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [15:0]                      out_tdata,
  input logic                             out_tuser
);
  import pcdac_pkg::*;

  logic [CODE_W-1:0] last_code_r;
  logic              have_r;

  // last code seen with the write strobe set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tuser) begin
      have_r      <= 1'b1;
      last_code_r <= out_tdata[CODE_W-1:0];
    end
  end

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one item in flight: the input closes after each transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // two strobed writes in a row never carry the same code
  a_strobe_changes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser && have_r
      |-> out_tdata[CODE_W-1:0] != last_code_r)
    else $error("write strobe on an unchanged code");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

endmodule

bind pulsed_current_dac_code_generator_unit pcdac_checker u_pcdac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
